// File: src/rsamx_pkg.sv
// Shared types and constants for the RSA modular exponentiation block.
package rsamx_pkg;

    // Fixed widths of the item and register fields.
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd2;

    // Input item modes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Output status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_KEYS = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_EXP,
        S_DBL,
        S_ADD,
        S_UPD,
        S_FINISH
    } t_state;

endpackage

// File: src/rsa_char_modexp_cipher.sv
// Top level: bit-serial RSA modular exponentiation, one value per transaction.
// Each accepted transaction raises its value to the public exponent (mode 0, low byte of
// the value only) or to the private exponent (mode 1, low byte of the result returned)
// modulo the low MOD_BITS bits of the key modulus, by right-to-left square-and-multiply.
// The value is first reduced modulo the modulus, one value bit per cycle. Then, for each
// exponent bit up to the highest set one, the multiply and the square run side by side as
// two interleaved shift-and-add modular multipliers that share the bits of the running
// base, with a doubling step and an add step per bit; the base then takes the square, and
// the accumulator the product if the bit is set. When the keys are not set the result is
// zero with status 1. One transaction is worked at a time; the next is taken while the
// previous result waits in the output register.
// Configuration writes are always ready and must only be made while the block is idle.
module rsa_char_modexp_cipher
    import rsamx_pkg::*;
#(
    parameter int MOD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input item channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_mode,
    input  logic [VALUE_W-1:0]   i_value,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [VALUE_W-1:0]   o_result,
    output logic                 o_status,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data
);

    localparam int W = MOD_BITS;

    // Control and configuration registers
    t_state               r_state, n_state;
    logic                 r_o_valid, n_o_valid;
    logic [VALUE_W-1:0]   r_pub_exp, r_priv_exp, r_key_modulus;

    // Datapath registers
    logic [W-1:0]         r_base, n_base;
    logic [W-1:0]         r_acc, n_acc;
    logic [W-1:0]         r_p1, n_p1;
    logic [W-1:0]         r_p2, n_p2;
    logic [W-1:0]         r_mulr, n_mulr;
    logic [VALUE_W-1:0]   r_exp, n_exp;
    logic [VALUE_W-1:0]   r_vshift, n_vshift;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_mode, n_mode;
    logic                 r_err, n_err;
    logic [VALUE_W-1:0]   r_result, n_result;
    logic                 r_status, n_status;

    // Combinational helpers
    logic [W-1:0]         w_m;
    logic [W:0]           w_m_ext;
    logic                 w_keys_ok;
    logic                 w_out_free;
    logic [W:0]           w_red_t, w_dbl1_t, w_dbl2_t, w_add1_t, w_add2_t;
    logic [W-1:0]         w_red, w_dbl1, w_dbl2, w_add1, w_add2;

    assign w_m     = r_key_modulus[W-1:0];
    assign w_m_ext = {1'b0, w_m};

    // Keys must be set; decryption also needs the private exponent.
    assign w_keys_ok = (w_m != '0) && (r_pub_exp != '0) &&
                       ((i_mode == MODE_ENCRYPT) || (r_priv_exp != '0));

    // The output register can take a new result this cycle.
    assign w_out_free = !r_o_valid || !i_stall;

    // Reduction step: shift in one value bit and subtract the modulus once if needed.
    assign w_red_t = {r_base, r_vshift[VALUE_W-1]};
    assign w_red   = (w_red_t >= w_m_ext) ? W'(w_red_t - w_m_ext) : w_red_t[W-1:0];

    // Doubling step of both multipliers.
    assign w_dbl1_t = {r_p1, 1'b0};
    assign w_dbl2_t = {r_p2, 1'b0};
    assign w_dbl1   = (w_dbl1_t >= w_m_ext) ? W'(w_dbl1_t - w_m_ext) : w_dbl1_t[W-1:0];
    assign w_dbl2   = (w_dbl2_t >= w_m_ext) ? W'(w_dbl2_t - w_m_ext) : w_dbl2_t[W-1:0];

    // Add step: multiply adds the accumulator, square adds the base.
    assign w_add1_t = {1'b0, r_p1} + {1'b0, r_acc};
    assign w_add2_t = {1'b0, r_p2} + {1'b0, r_base};
    assign w_add1   = (w_add1_t >= w_m_ext) ? W'(w_add1_t - w_m_ext) : w_add1_t[W-1:0];
    assign w_add2   = (w_add2_t >= w_m_ext) ? W'(w_add2_t - w_m_ext) : w_add2_t[W-1:0];

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state  = r_state;
        n_o_valid = r_o_valid;
        n_base   = r_base;
        n_acc    = r_acc;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_mulr   = r_mulr;
        n_exp    = r_exp;
        n_vshift = r_vshift;
        n_cnt    = r_cnt;
        n_mode   = r_mode;
        n_err    = r_err;
        n_result = r_result;
        n_status = r_status;

        // A waiting result leaves when the receiver does not stall.
        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode   = i_mode;
                    n_err    = !w_keys_ok;
                    n_exp    = (i_mode == MODE_DECRYPT) ? r_priv_exp : r_pub_exp;
                    n_vshift = (i_mode == MODE_DECRYPT) ? i_value : VALUE_W'(i_value[7:0]);
                    n_base   = '0;
                    n_acc    = {{(W-1){1'b0}}, (w_m != W'(1))};
                    n_cnt    = '0;
                    n_state  = w_keys_ok ? S_REDUCE : S_FINISH;
                end
            end
            S_REDUCE: begin
                n_base   = w_red;
                n_vshift = {r_vshift[VALUE_W-2:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                if (r_exp == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_mulr  = r_base;
                    n_p1    = '0;
                    n_p2    = '0;
                    n_cnt   = '0;
                    n_state = S_DBL;
                end
            end
            S_DBL: begin
                n_p1    = w_dbl1;
                n_p2    = w_dbl2;
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_mulr[W-1]) begin
                    n_p1 = w_add1;
                    n_p2 = w_add2;
                end
                n_mulr = {r_mulr[W-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                n_state = (r_cnt == CNT_W'(W - 1)) ? S_UPD : S_DBL;
            end
            S_UPD: begin
                if (r_exp[0]) begin
                    n_acc = r_p1;
                end
                n_base  = r_p2;
                n_exp   = {1'b0, r_exp[VALUE_W-1:1]};
                n_state = S_EXP;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    if (r_err) begin
                        n_result = '0;
                        n_status = STATUS_NO_KEYS;
                    end else begin
                        n_result = (r_mode == MODE_DECRYPT) ? VALUE_W'(r_acc[7:0])
                                                            : VALUE_W'(r_acc);
                        n_status = STATUS_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_o_valid     <= 1'b0;
            r_pub_exp     <= '0;
            r_priv_exp    <= '0;
            r_key_modulus <= '0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PUB_EXP:  r_pub_exp     <= i_cfg_data;
                    CFG_PRIV_EXP: r_priv_exp    <= i_cfg_data;
                    CFG_MODULUS:  r_key_modulus <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_base   <= n_base;
        r_acc    <= n_acc;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_mulr   <= n_mulr;
        r_exp    <= n_exp;
        r_vshift <= n_vshift;
        r_cnt    <= n_cnt;
        r_mode   <= n_mode;
        r_err    <= n_err;
        r_result <= n_result;
        r_status <= n_status;
    end

    // Ports.
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;
    assign o_cfg_ready = 1'b1;

endmodule
